### sv/recurring_device_pass_tracker_macros.svh
// ----------------------------------------------------------------------------
// recurring device pass tracker assertion macros
// shared concurrent assertion forms, clocked on clock, disabled in reset
// ----------------------------------------------------------------------------
`ifndef RECURRING_DEVICE_PASS_TRACKER_MACROS_SVH
`define RECURRING_DEVICE_PASS_TRACKER_MACROS_SVH

// same-cycle implication
`define RDPT_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RDPT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/rdpt_pkg.sv
// ----------------------------------------------------------------------------
// rdpt_pkg
// shared constants and types of the recurring device pass tracker
// ----------------------------------------------------------------------------
package rdpt_pkg;

   localparam int DEVICE_SLOTS_DEF = 32;
   localparam int PASS_SLOTS_DEF   = 16;

   localparam int MAC_W   = 48;
   localparam int TIME_W  = 32;
   localparam int RSSI_W  = 8;
   localparam int WIN_W   = 31;
   localparam int CNT_W   = 5;
   localparam int GAP_W   = 17;
   localparam int STALE_W = 20;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam logic [GAP_W-1:0]   GAP_RESET   = GAP_W'(60);
   localparam logic [STALE_W-1:0] STALE_RESET = STALE_W'(3600);

   typedef enum logic [1:0] {
      OP_OBSERVE = 2'd0,
      OP_COUNT   = 2'd1,
      OP_SWEEP   = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAP   = 2'd0,
      CSR_STALE = 2'd1
   } csr_idx_type;

endpackage

### sv/recurring_device_pass_tracker.sv
// ----------------------------------------------------------------------------
// recurring device pass tracker
// device table keyed by mac with per-device pass history, sweep and dump
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays high
// until the final result has been issued. Results appear for a single cycle
// marked by rsp_valid and cannot be held off, so the receiver must take every
// strobe. Observe, count and clear give one result; sweep gives one result per
// remaining device (rsp_last on the final one), or one empty result. A
// sequencer walks the device record memory one entry at a time: observe
// searches the held devices and shifts a full pass list; count searches and
// then reads the stored passes; sweep checks each entry, moves the last
// entry and its passes into each removed one, then dumps the rest; clear
// empties the table. No clearing pass is needed after reset. Configuration
// writes are always accepted.
// ----------------------------------------------------------------------------
module recurring_device_pass_tracker #(
   parameter int DEVICE_SLOTS = rdpt_pkg::DEVICE_SLOTS_DEF,
   parameter int PASS_SLOTS   = rdpt_pkg::PASS_SLOTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // command transaction
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_operation,
   input  logic [rdpt_pkg::MAC_W-1:0]         req_mac,
   input  logic [rdpt_pkg::TIME_W-1:0]        req_timestamp,
   input  logic signed [rdpt_pkg::RSSI_W-1:0] req_peak_rssi,
   input  logic [rdpt_pkg::WIN_W-1:0]         req_window_secs,
   // result transaction
   output logic                               rsp_valid,
   output logic [rdpt_pkg::CNT_W-1:0]         rsp_pass_total,
   output logic                               rsp_entry_valid,
   output logic [rdpt_pkg::MAC_W-1:0]         rsp_entry_mac,
   output logic [rdpt_pkg::TIME_W-1:0]        rsp_entry_first_seen,
   output logic [rdpt_pkg::TIME_W-1:0]        rsp_entry_last_seen,
   output logic signed [rdpt_pkg::RSSI_W-1:0] rsp_entry_best_rssi,
   output logic [rdpt_pkg::CNT_W-1:0]         rsp_entry_passes,
   output logic                               rsp_last,
   // configuration transaction
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rdpt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rdpt_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rdpt_pkg::*;

   `include "recurring_device_pass_tracker_macros.svh"

   localparam int SW = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1; // slot index
   localparam int CW = $clog2(DEVICE_SLOTS + 1);                     // slot count
   localparam int PW = (PASS_SLOTS > 1) ? $clog2(PASS_SLOTS) : 1;     // pass index
   localparam int FW = $clog2(PASS_SLOTS + 1);                       // pass count

   // one device record as held in the record memory
   typedef struct packed {
      logic [MAC_W-1:0]         key;
      logic [TIME_W-1:0]        first;
      logic [TIME_W-1:0]        last;
      logic signed [RSSI_W-1:0] rssi;
      logic [FW-1:0]            fill;
   } rec_type;

   typedef enum logic [21:0] {
      S_IDLE     = 22'h000001,
      S_SCAN_RD  = 22'h000002,
      S_SCAN_CHK = 22'h000004,
      S_OBS_NEW  = 22'h000008,
      S_OBS_UPD  = 22'h000010,
      S_PASS_RD  = 22'h000020,
      S_PASS_CHK = 22'h000040,
      S_PASS_APP = 22'h000080,
      S_SHIFT_RD = 22'h000100,
      S_SHIFT_WR = 22'h000200,
      S_OBS_WB   = 22'h000400,
      S_CNT_RD   = 22'h000800,
      S_CNT_CHK  = 22'h001000,
      S_SWP_RD   = 22'h002000,
      S_SWP_CHK  = 22'h004000,
      S_MOV_RD   = 22'h008000,
      S_MOV_WR   = 22'h010000,
      S_CPY_RD   = 22'h020000,
      S_CPY_WR   = 22'h040000,
      S_DMP_RD   = 22'h080000,
      S_DMP_EMIT = 22'h100000,
      S_RESP     = 22'h200000
   } state_type;

   // control state
   state_type          state_ff, state_in;
   logic [CW-1:0]      used_ff, used_in;
   logic [GAP_W-1:0]   gap_ff, gap_in;
   logic [STALE_W-1:0] stale_ff, stale_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // working registers
   op_type             op_ff, op_in;
   logic [MAC_W-1:0]   mac_ff, mac_in;
   logic [TIME_W-1:0]  ts_ff, ts_in;
   logic signed [RSSI_W-1:0] rssi_ff, rssi_in;
   logic [WIN_W-1:0]   win_ff, win_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [SW-1:0]      slot_ff, slot_in;
   logic [SW-1:0]      src_ff, src_in;
   logic [SW-1:0]      old_idx_ff, old_idx_in;
   logic [TIME_W-1:0]  old_last_ff, old_last_in;
   logic [FW-1:0]      j_ff, j_in;
   logic [FW-1:0]      n_ff, n_in;
   rec_type            work_ff, work_in;

   // result registers
   logic [CNT_W-1:0]   rsp_total_ff, rsp_total_in;
   logic               rsp_ev_ff, rsp_ev_in;
   rec_type            rsp_rec_ff, rsp_rec_in;
   logic               rsp_last_ff, rsp_last_in;

   // record memory
   rec_type            rec_mem [DEVICE_SLOTS];
   rec_type            rec_rd_ff;
   logic [SW-1:0]      rec_raddr;
   logic               rec_we;
   logic [SW-1:0]      rec_waddr;
   rec_type            rec_wdata;

   // pass memory
   logic               ps_we;
   logic [SW-1:0]      ps_wslot;
   logic [PW-1:0]      ps_wpos;
   logic [TIME_W-1:0]  ps_wdata;
   logic [SW-1:0]      ps_rslot;
   logic [PW-1:0]      ps_rpos;
   logic [TIME_W-1:0]  ps_rdata;

   // shared arithmetic
   logic [TIME_W-1:0]  diff;
   logic [TIME_W-1:0]  swp_age;
   logic               swp_stale;

   rdpt_pass_store #(
      .DEVICE_SLOTS (DEVICE_SLOTS),
      .PASS_SLOTS   (PASS_SLOTS),
      .SW           (SW),
      .PW           (PW)
   ) u_pass_store (
      .clock   (clock),
      .wr_en   (ps_we),
      .wr_slot (ps_wslot),
      .wr_pos  (ps_wpos),
      .wr_data (ps_wdata),
      .rd_slot (ps_rslot),
      .rd_pos  (ps_rpos),
      .rd_data (ps_rdata)
   );

   // record memory, one write and one registered read port
   assign rec_raddr = (state_ff == S_MOV_RD) ? src_ff : idx_ff[SW-1:0];

   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[rec_waddr] <= rec_wdata;
      end
      rec_rd_ff <= rec_mem[rec_raddr];
   end

   // absolute distance between the sighting and the last stored pass
   assign diff = (ts_ff >= ps_rdata) ? (ts_ff - ps_rdata) : (ps_rdata - ts_ff);

   // sweep age, negative ages never go stale
   assign swp_age   = ts_ff - rec_rd_ff.last;
   assign swp_stale = (ts_ff >= rec_rd_ff.last) && (swp_age > TIME_W'(stale_ff));

   // the sequencer
   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      gap_in       = gap_ff;
      stale_in     = stale_ff;
      op_in        = op_ff;
      mac_in       = mac_ff;
      ts_in        = ts_ff;
      rssi_in      = rssi_ff;
      win_in       = win_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      src_in       = src_ff;
      old_idx_in   = old_idx_ff;
      old_last_in  = old_last_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      work_in      = work_ff;
      rsp_valid_in = 1'b0;
      rsp_total_in = rsp_total_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_rec_in   = rsp_rec_ff;
      rsp_last_in  = rsp_last_ff;
      rec_we       = 1'b0;
      rec_waddr    = slot_ff;
      rec_wdata    = work_ff;
      ps_we        = 1'b0;
      ps_wslot     = slot_ff;
      ps_wpos      = PW'(j_ff);
      ps_wdata     = ts_ff;
      ps_rslot     = slot_ff;
      ps_rpos      = PW'(j_ff);

      // register writes
      if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_GAP: begin
               gap_in = csr_wdata[GAP_W-1:0];
            end
            CSR_STALE: begin
               stale_in = csr_wdata[STALE_W-1:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in   = op_type'(req_operation);
               mac_in  = req_mac;
               ts_in   = req_timestamp;
               rssi_in = req_peak_rssi;
               win_in  = req_window_secs;
               idx_in  = '0;
               n_in    = '0;
               case (op_type'(req_operation))
                  OP_OBSERVE, OP_COUNT: begin
                     state_in = S_SCAN_RD;
                  end
                  OP_SWEEP: begin
                     state_in = S_SWP_RD;
                  end
                  default: begin
                     used_in  = '0;
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         // key search, also tracks the oldest entry for eviction
         S_SCAN_RD: begin
            if (idx_ff == used_ff) begin
               state_in = (op_ff == OP_OBSERVE) ? S_OBS_NEW : S_RESP;
            end else begin
               state_in = S_SCAN_CHK;
            end
         end

         S_SCAN_CHK: begin
            if (rec_rd_ff.key == mac_ff) begin
               work_in  = rec_rd_ff;
               slot_in  = idx_ff[SW-1:0];
               j_in     = '0;
               state_in = (op_ff == OP_OBSERVE) ? S_OBS_UPD : S_CNT_RD;
            end else begin
               if ((idx_ff == '0) || (rec_rd_ff.last < old_last_ff)) begin
                  old_idx_in  = idx_ff[SW-1:0];
                  old_last_in = rec_rd_ff.last;
               end
               idx_in   = idx_ff + CW'(1);
               state_in = S_SCAN_RD;
            end
         end

         // new device: free slot or evict the oldest
         S_OBS_NEW: begin
            if (used_ff < CW'(DEVICE_SLOTS)) begin
               slot_in = used_ff[SW-1:0];
               used_in = used_ff + CW'(1);
            end else begin
               slot_in = old_idx_ff;
            end
            work_in.key   = mac_ff;
            work_in.first = ts_ff;
            work_in.last  = '0;
            work_in.rssi  = '0;
            work_in.fill  = '0;
            state_in      = S_OBS_UPD;
         end

         S_OBS_UPD: begin
            if ((rssi_ff != '0) && ((work_ff.rssi == '0) || (rssi_ff > work_ff.rssi))) begin
               work_in.rssi = rssi_ff;
            end
            if (ts_ff > work_ff.last) begin
               work_in.last = ts_ff;
            end
            if ((work_ff.first == '0) || (ts_ff < work_ff.first)) begin
               work_in.first = ts_ff;
            end
            state_in = (work_ff.fill != '0) ? S_PASS_RD : S_PASS_APP;
         end

         S_PASS_RD: begin
            ps_rpos  = PW'(work_ff.fill - FW'(1));
            state_in = S_PASS_CHK;
         end

         S_PASS_CHK: begin
            state_in = (diff < TIME_W'(gap_ff)) ? S_OBS_WB : S_PASS_APP;
         end

         S_PASS_APP: begin
            if (work_ff.fill < FW'(PASS_SLOTS)) begin
               ps_we        = 1'b1;
               ps_wpos      = PW'(work_ff.fill);
               work_in.fill = work_ff.fill + FW'(1);
               state_in     = S_OBS_WB;
            end else begin
               j_in     = '0;
               state_in = S_SHIFT_RD;
            end
         end

         // full list: move every pass down one place, newest at the end
         S_SHIFT_RD: begin
            if (j_ff == FW'(PASS_SLOTS - 1)) begin
               ps_we    = 1'b1;
               state_in = S_OBS_WB;
            end else begin
               ps_rpos  = PW'(j_ff + FW'(1));
               state_in = S_SHIFT_WR;
            end
         end

         S_SHIFT_WR: begin
            ps_we    = 1'b1;
            ps_wdata = ps_rdata;
            j_in     = j_ff + FW'(1);
            state_in = S_SHIFT_RD;
         end

         S_OBS_WB: begin
            rec_we   = 1'b1;
            state_in = S_RESP;
         end

         // count passes within the window
         S_CNT_RD: begin
            state_in = (j_ff == work_ff.fill) ? S_RESP : S_CNT_CHK;
         end

         S_CNT_CHK: begin
            if (((ts_ff > ps_rdata) ? (ts_ff - ps_rdata) : '0) <= TIME_W'(win_ff)) begin
               n_in = n_ff + FW'(1);
            end
            j_in     = j_ff + FW'(1);
            state_in = S_CNT_RD;
         end

         // sweep stale entries, last entry fills the hole
         S_SWP_RD: begin
            if (idx_ff == used_ff) begin
               idx_in   = '0;
               state_in = (used_ff == '0) ? S_RESP : S_DMP_RD;
            end else begin
               state_in = S_SWP_CHK;
            end
         end

         S_SWP_CHK: begin
            if (swp_stale) begin
               used_in  = used_ff - CW'(1);
               src_in   = SW'(used_ff - CW'(1));
               state_in = S_MOV_RD;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_SWP_RD;
            end
         end

         S_MOV_RD: begin
            state_in = S_MOV_WR;
         end

         S_MOV_WR: begin
            rec_we    = 1'b1;
            rec_waddr = idx_ff[SW-1:0];
            rec_wdata = rec_rd_ff;
            j_in      = '0;
            state_in  = S_CPY_RD;
         end

         S_CPY_RD: begin
            ps_rslot = src_ff;
            state_in = (j_ff == FW'(PASS_SLOTS)) ? S_SWP_RD : S_CPY_WR;
         end

         S_CPY_WR: begin
            ps_we    = 1'b1;
            ps_wslot = idx_ff[SW-1:0];
            ps_wdata = ps_rdata;
            j_in     = j_ff + FW'(1);
            state_in = S_CPY_RD;
         end

         // dump every remaining entry
         S_DMP_RD: begin
            state_in = S_DMP_EMIT;
         end

         S_DMP_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_total_in = '0;
            rsp_ev_in    = 1'b1;
            rsp_rec_in   = rec_rd_ff;
            rsp_last_in  = ((idx_ff + CW'(1)) == used_ff);
            idx_in       = idx_ff + CW'(1);
            state_in     = ((idx_ff + CW'(1)) == used_ff) ? S_IDLE : S_DMP_RD;
         end

         // single result of observe, count, clear or an empty sweep
         S_RESP: begin
            rsp_valid_in = 1'b1;
            rsp_total_in = CNT_W'(n_ff);
            rsp_ev_in    = 1'b0;
            rsp_rec_in   = '0;
            rsp_last_in  = 1'b1;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         gap_ff       <= GAP_RESET;
         stale_ff     <= STALE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         gap_ff       <= gap_in;
         stale_ff     <= stale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      mac_ff       <= mac_in;
      ts_ff        <= ts_in;
      rssi_ff      <= rssi_in;
      win_ff       <= win_in;
      idx_ff       <= idx_in;
      slot_ff      <= slot_in;
      src_ff       <= src_in;
      old_idx_ff   <= old_idx_in;
      old_last_ff  <= old_last_in;
      j_ff         <= j_in;
      n_ff         <= n_in;
      work_ff      <= work_in;
      rsp_total_ff <= rsp_total_in;
      rsp_ev_ff    <= rsp_ev_in;
      rsp_rec_ff   <= rsp_rec_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign busy                 = (state_ff != S_IDLE);
   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pass_total       = rsp_total_ff;
   assign rsp_entry_valid      = rsp_ev_ff;
   assign rsp_entry_mac        = rsp_rec_ff.key;
   assign rsp_entry_first_seen = rsp_rec_ff.first;
   assign rsp_entry_last_seen  = rsp_rec_ff.last;
   assign rsp_entry_best_rssi  = rsp_rec_ff.rssi;
   assign rsp_entry_passes     = CNT_W'(rsp_rec_ff.fill);
   assign rsp_last             = rsp_last_ff;

   // table occupancy never exceeds the slot count
   `RDPT_ASSERT_SAME(a_used_bound, 1'b1, used_ff <= CW'(DEVICE_SLOTS), "used slots overflow")
   // an accepted transaction makes the block busy
   `RDPT_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted command not busy")
   // the final result of a transaction is never followed straight by another
   `RDPT_ASSERT_NEXT(a_last_gap, rsp_valid && rsp_last, !rsp_valid, "result after last")
   // dumped entries carry no pass total
   `RDPT_ASSERT_SAME(a_dump_total, rsp_valid && rsp_entry_valid, rsp_pass_total == '0,
                     "dump result with pass total")

endmodule

### sv/rdpt_pass_store.sv
// ----------------------------------------------------------------------------
// rdpt_pass_store
// pass time memory, one row of pass slots per device, registered read
// ----------------------------------------------------------------------------
module rdpt_pass_store #(
   parameter int DEVICE_SLOTS = rdpt_pkg::DEVICE_SLOTS_DEF,
   parameter int PASS_SLOTS   = rdpt_pkg::PASS_SLOTS_DEF,
   parameter int SW = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1,
   parameter int PW = (PASS_SLOTS > 1) ? $clog2(PASS_SLOTS) : 1
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [SW-1:0]                 wr_slot,
   input  logic [PW-1:0]                 wr_pos,
   input  logic [rdpt_pkg::TIME_W-1:0]   wr_data,
   input  logic [SW-1:0]                 rd_slot,
   input  logic [PW-1:0]                 rd_pos,
   output logic [rdpt_pkg::TIME_W-1:0]   rd_data
);
   import rdpt_pkg::*;

   localparam int DEPTH = DEVICE_SLOTS * PASS_SLOTS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [TIME_W-1:0] mem [DEPTH];
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr;
   logic [TIME_W-1:0] rd_data_ff;

   // row base times row length plus position
   assign wr_addr = AW'(wr_slot) * AW'(PASS_SLOTS) + AW'(wr_pos);
   assign rd_addr = AW'(rd_slot) * AW'(PASS_SLOTS) + AW'(rd_pos);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// recurring device pass tracker testbench
// drives observe, count, sweep and clear commands plus register writes, and
// checks every result strobe against an in-bench model of the device table
// ----------------------------------------------------------------------------
module tb;
   import rdpt_pkg::*;

   localparam int SLOTS  = 32;
   localparam int PASSES = 16;

   // one result strobe as seen on the rsp_ ports
   typedef struct {
      logic [CNT_W-1:0]         total;
      logic                     ev;
      logic [MAC_W-1:0]         mac;
      logic [TIME_W-1:0]        first_time;
      logic [TIME_W-1:0]        last_time;
      logic signed [RSSI_W-1:0] rssi;
      logic [CNT_W-1:0]         passes;
      logic                     fin;
   } rsp_item_type;

   // one row of the directed stimulus; pin >= 0 types in the pass_total of
   // the single result of an observe, count or clear
   typedef struct {
      op_type                   op;
      logic [MAC_W-1:0]         mac;
      logic [TIME_W-1:0]        ts;
      logic signed [RSSI_W-1:0] rssi;
      logic [WIN_W-1:0]         win;
      int                       pin;
   } cmd_row_type;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [1:0]                 req_operation;
   logic [MAC_W-1:0]           req_mac;
   logic [TIME_W-1:0]          req_timestamp;
   logic signed [RSSI_W-1:0]   req_peak_rssi;
   logic [WIN_W-1:0]           req_window_secs;
   logic                       rsp_valid;
   logic [CNT_W-1:0]           rsp_pass_total;
   logic                       rsp_entry_valid;
   logic [MAC_W-1:0]           rsp_entry_mac;
   logic [TIME_W-1:0]          rsp_entry_first_seen;
   logic [TIME_W-1:0]          rsp_entry_last_seen;
   logic signed [RSSI_W-1:0]   rsp_entry_best_rssi;
   logic [CNT_W-1:0]           rsp_entry_passes;
   logic                       rsp_last;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]      csr_wdata;
   // typed-in expectation travels with the command, like a request field
   int                         pin_q;

   recurring_device_pass_tracker u_top (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_operation        (req_operation),
      .req_mac              (req_mac),
      .req_timestamp        (req_timestamp),
      .req_peak_rssi        (req_peak_rssi),
      .req_window_secs      (req_window_secs),
      .rsp_valid            (rsp_valid),
      .rsp_pass_total       (rsp_pass_total),
      .rsp_entry_valid      (rsp_entry_valid),
      .rsp_entry_mac        (rsp_entry_mac),
      .rsp_entry_first_seen (rsp_entry_first_seen),
      .rsp_entry_last_seen  (rsp_entry_last_seen),
      .rsp_entry_best_rssi  (rsp_entry_best_rssi),
      .rsp_entry_passes     (rsp_entry_passes),
      .rsp_last             (rsp_last),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // device table mirror
   // ---------------------------------------------------------------------
   logic [GAP_W-1:0]          gap_cfg;
   logic [STALE_W-1:0]        stale_cfg;
   logic [MAC_W-1:0]          dev_mac   [SLOTS];
   logic [TIME_W-1:0]         dev_first [SLOTS];
   logic [TIME_W-1:0]         dev_last  [SLOTS];
   logic signed [RSSI_W-1:0]  dev_rssi  [SLOTS];
   int                        dev_fill  [SLOTS];
   logic [TIME_W-1:0]         dev_pass  [SLOTS][PASSES];
   int                        dev_count;

   rsp_item_type              pending_rsp[$];
   bit                        failed;

   function automatic int lookup_device(logic [MAC_W-1:0] mac);
      for (int i = 0; i < dev_count; i++)
         if (dev_mac[i] == mac) return i;
      return -1;
   endfunction

   // observe: find or take a slot (evicting the stalest), then update it
   function automatic void record_sighting(logic [MAC_W-1:0] mac, logic [TIME_W-1:0] ts,
                                           logic signed [RSSI_W-1:0] rssi);
      int                s;
      logic [TIME_W-1:0] prev;
      logic [TIME_W-1:0] spacing;
      s = lookup_device(mac);
      if (s < 0) begin
         if (dev_count < SLOTS) begin
            s = dev_count;
            dev_count++;
         end else begin
            // lowest index wins a tie, so only a strictly older entry moves it
            s = 0;
            for (int i = 1; i < SLOTS; i++)
               if (dev_last[i] < dev_last[s]) s = i;
         end
         dev_mac[s]   = mac;
         dev_first[s] = ts;
         dev_last[s]  = '0;
         dev_rssi[s]  = '0;
         dev_fill[s]  = 0;
      end
      if (rssi != 0 && (dev_rssi[s] == 0 || rssi > dev_rssi[s])) dev_rssi[s] = rssi;
      if (ts > dev_last[s]) dev_last[s] = ts;
      // a first sighting time of zero counts as unset
      if (dev_first[s] == 0 || ts < dev_first[s]) dev_first[s] = ts;
      if (dev_fill[s] > 0) begin
         prev    = dev_pass[s][dev_fill[s]-1];
         spacing = (ts >= prev) ? ts - prev : prev - ts;
         if (spacing < TIME_W'(gap_cfg)) return;
      end
      if (dev_fill[s] < PASSES) begin
         dev_pass[s][dev_fill[s]] = ts;
         dev_fill[s]++;
      end else begin
         // full pass list drops its oldest
         for (int j = 0; j < PASSES - 1; j++) dev_pass[s][j] = dev_pass[s][j+1];
         dev_pass[s][PASSES-1] = ts;
      end
   endfunction

   function automatic int passes_in_window(logic [MAC_W-1:0] mac, logic [TIME_W-1:0] now,
                                           logic [WIN_W-1:0] win);
      int                s;
      int                n;
      logic [TIME_W-1:0] age;
      s = lookup_device(mac);
      n = 0;
      if (s < 0) return 0;
      for (int j = 0; j < dev_fill[s]; j++) begin
         // a pass later than now has age zero
         age = (now > dev_pass[s][j]) ? now - dev_pass[s][j] : '0;
         if (age <= TIME_W'(win)) n++;
      end
      return n;
   endfunction

   function automatic rsp_item_type empty_rsp(int total);
      rsp_item_type r;
      r = '{total: CNT_W'(total), ev: 1'b0, mac: '0, first_time: '0, last_time: '0,
            rssi: '0, passes: '0, fin: 1'b1};
      return r;
   endfunction

   // sweep: drop stale devices (last entry fills the hole), then dump all
   function automatic void sweep_and_dump(logic [TIME_W-1:0] now);
      int           i;
      rsp_item_type r;
      i = 0;
      while (i < dev_count) begin
         if (now > dev_last[i] && (now - dev_last[i]) > TIME_W'(stale_cfg)) begin
            dev_count--;
            dev_mac[i]   = dev_mac[dev_count];
            dev_first[i] = dev_first[dev_count];
            dev_last[i]  = dev_last[dev_count];
            dev_rssi[i]  = dev_rssi[dev_count];
            dev_fill[i]  = dev_fill[dev_count];
            dev_pass[i]  = dev_pass[dev_count];
         end else begin
            i++;
         end
      end
      if (dev_count == 0) begin
         pending_rsp.push_back(empty_rsp(0));
         return;
      end
      for (int k = 0; k < dev_count; k++) begin
         r = '{total: '0, ev: 1'b1, mac: dev_mac[k], first_time: dev_first[k],
               last_time: dev_last[k], rssi: dev_rssi[k], passes: CNT_W'(dev_fill[k]),
               fin: (k == dev_count - 1)};
         pending_rsp.push_back(r);
      end
   endfunction

   function automatic void predict_command(logic [1:0] op, logic [MAC_W-1:0] mac,
                                           logic [TIME_W-1:0] ts,
                                           logic signed [RSSI_W-1:0] rssi,
                                           logic [WIN_W-1:0] win, int pin);
      int cnt;
      cnt = 0;
      case (op)
         OP_OBSERVE: record_sighting(mac, ts, rssi);
         OP_COUNT:   cnt = passes_in_window(mac, ts, win);
         OP_CLEAR:   dev_count = 0;
         default: begin
            sweep_and_dump(ts);
            return;
         end
      endcase
      pending_rsp.push_back(empty_rsp(pin >= 0 ? pin : cnt));
   endfunction

   // ---------------------------------------------------------------------
   // clock, timeout
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // timeout, far beyond the longest sweep
   initial begin
      #50000000;
      $display("recurring_device_pass_tracker verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // monitor: predicts on each accepted transaction, checks each strobe
   // ---------------------------------------------------------------------
   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: mismatch %s expected %0h actual %0h", $time, name, want, got);
         failed = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_GAP) gap_cfg = GAP_W'(csr_wdata);
            else if (csr_index == CSR_STALE) stale_cfg = STALE_W'(csr_wdata);
         end
         if (start && !busy)
            predict_command(req_operation, req_mac, req_timestamp, req_peak_rssi,
                            req_window_secs, pin_q);
         if (rsp_valid) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected result transaction", $time);
               failed = 1'b1;
            end else begin
               e = pending_rsp.pop_front();
               check_field("pass_total", 64'(e.total), 64'(rsp_pass_total));
               check_field("entry_valid", 64'(e.ev), 64'(rsp_entry_valid));
               check_field("entry_mac", 64'(e.mac), 64'(rsp_entry_mac));
               check_field("entry_first_seen", 64'(e.first_time), 64'(rsp_entry_first_seen));
               check_field("entry_last_seen", 64'(e.last_time), 64'(rsp_entry_last_seen));
               check_field("entry_best_rssi", 64'(e.rssi), 64'(rsp_entry_best_rssi));
               check_field("entry_passes", 64'(e.passes), 64'(rsp_entry_passes));
               check_field("last", 64'(e.fin), 64'(rsp_last));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // driver
   // ---------------------------------------------------------------------
   cmd_row_type directed_rows[$];

   function automatic void add_row(op_type op, logic [MAC_W-1:0] mac, logic [TIME_W-1:0] ts,
                                   logic signed [RSSI_W-1:0] rssi, logic [WIN_W-1:0] win,
                                   int pin);
      directed_rows.push_back('{op: op, mac: mac, ts: ts, rssi: rssi, win: win, pin: pin});
   endfunction

   // start stays high on return; the caller either sends again or idles
   task automatic send_command(cmd_row_type c);
      start           <= 1'b1;
      req_operation   <= c.op;
      req_mac         <= c.mac;
      req_timestamp   <= c.ts;
      req_peak_rssi   <= c.rssi;
      req_window_secs <= c.win;
      pin_q           <= c.pin;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_cycles(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // csr_valid stays high on return; the caller drops it after the last write
   task automatic write_register(csr_idx_type idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // wait until the block is idle and every expected result has arrived
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (busy || pending_rsp.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      logic [MAC_W-1:0]  mac_pool[40];
      logic [TIME_W-1:0] now_s;
      cmd_row_type       c;
      int                pool_n;
      int                pick;
      logic [GAP_W-1:0]  gap_pick [5];
      logic [STALE_W-1:0] stale_pick [5];

      failed          = 1'b0;
      gap_cfg         = GAP_RESET;
      stale_cfg       = STALE_RESET;
      dev_count       = 0;
      reset           = 1'b1;
      start           = 1'b0;
      req_operation   = OP_OBSERVE;
      req_mac         = '0;
      req_timestamp   = '0;
      req_peak_rssi   = '0;
      req_window_secs = '0;
      pin_q           = -1;
      csr_valid       = 1'b0;
      csr_index       = CSR_GAP;
      csr_wdata       = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, reset register values
      add_row(OP_COUNT,   48'h1234, 32'd5, 8'sd0, 31'd100, 0);       // nothing stored
      add_row(OP_SWEEP,   '0, '0, 8'sd0, '0, 0);                     // empty table
      add_row(OP_OBSERVE, '0, '0, 8'sd0, '0, 0);                     // first seen zero
      add_row(OP_OBSERVE, '0, 32'd100, -8'sd128, '0, 0);             // replaces first seen
      add_row(OP_OBSERVE, '1, '1, 8'sd127, '0, 0);
      add_row(OP_OBSERVE, '1, 32'hFFFF_FFF0, 8'sd3, '0, 0);          // inside the gap
      add_row(OP_OBSERVE, '0, 32'd50, 8'sd5, '0, 0);                 // spacing taken absolute
      add_row(OP_COUNT,   '0, '0, 8'sd0, '0, -1);                    // clock stepped back
      add_row(OP_COUNT,   '1, '1, 8'sd0, '1, -1);
      add_row(OP_COUNT,   48'hAAAA_5555_AAAA, '1, 8'sd0, '1, 0);
      add_row(OP_SWEEP,   '0, 32'd200, 8'sd0, '0, -1);
      add_row(OP_OBSERVE, 48'h5555_AAAA_5555, 32'd7200, -8'sd1, '0, 0);
      add_row(OP_SWEEP,   '0, 32'd7301, 8'sd0, '0, -1);              // stale removed, moved
      add_row(OP_SWEEP,   '0, '1, 8'sd0, '0, -1);
      add_row(OP_CLEAR,   '0, '0, 8'sd0, '0, 0);
      add_row(OP_SWEEP,   '0, '1, 8'sd0, '0, 0);                     // empty after clear
      foreach (directed_rows[i]) begin
         send_command(directed_rows[i]);
         if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 3));
      end
      drain();

      // register settings visited by the random phases, extremes included
      gap_pick   = '{GAP_W'(0), GAP_W'(1), GAP_W'(86400), '1, GAP_W'(30)};
      stale_pick = '{STALE_W'(0), STALE_W'(1), STALE_W'(604800), '1, STALE_W'(500)};

      // random phases: well-formed sighting streams over a pool of devices
      for (int ph = 0; ph < 6; ph++) begin
         write_register(CSR_GAP, CSR_DATA_W'(gap_pick[ph % 5]));
         write_register(CSR_STALE, CSR_DATA_W'(stale_pick[(ph + 2) % 5]));
         if (ph == 5) begin
            write_register(CSR_GAP, CSR_DATA_W'($urandom_range(0, 200)));
            write_register(CSR_STALE, CSR_DATA_W'($urandom_range(0, 2000)));
         end
         csr_valid <= 1'b0;
         // small pools revisit devices, large ones force eviction
         pool_n = (ph % 2 == 0) ? 12 : 40;
         for (int i = 0; i < pool_n; i++) mac_pool[i] = MAC_W'({$urandom, $urandom});
         now_s = (ph == 3) ? 32'hFFFF_0000 : $urandom_range(1, 1000000);

         for (int n = 0; n < 45; n++) begin
            pick  = $urandom_range(0, 99);
            now_s = now_s + $urandom_range(0, 150);
            c.mac  = mac_pool[$urandom_range(0, pool_n - 1)];
            c.ts   = now_s;
            c.rssi = ($urandom_range(0, 4) == 0) ? 8'sd0 : RSSI_W'($urandom);
            c.win  = ($urandom_range(0, 3) == 0) ? WIN_W'($urandom)
                                                 : WIN_W'($urandom_range(0, 3000));
            c.pin  = -1;
            if (pick < 70) begin
               c.op = OP_OBSERVE;
               // occasional noise: a wild timestamp or an unknown device
               if ($urandom_range(0, 15) == 0) c.ts = $urandom;
               if ($urandom_range(0, 15) == 0) c.mac = MAC_W'({$urandom, $urandom});
            end else if (pick < 86) begin
               c.op = OP_COUNT;
            end else if (pick < 97) begin
               c.op = OP_SWEEP;
               c.ts = now_s + $urandom_range(0, 3000);
            end else begin
               c.op = OP_CLEAR;
            end
            send_command(c);
            // no idling in the last phase
            if (ph < 5 && $urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 3));
         end
         drain();
      end

      drain();
      if (!failed)
         $display("recurring_device_pass_tracker verification clean");
      else
         $display("recurring_device_pass_tracker verification failed");
      $finish;
   end

endmodule
